// File: rtl/ihh_pkg.sv
`default_nettype none

package ihh_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ROUNDS_W = 16;
  localparam int unsigned BKT_W    = 12;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_W    = 13;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [ROUNDS_W-1:0] rounds_t;
  typedef logic [BKT_W-1:0]    bkt_t;
  typedef logic [OUT_W-1:0]    out_word_t;
  typedef logic [CFG_W-1:0]    cfg_word_t;

  // Commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Mixer constants
  localparam key_t GOLDEN = 32'h9e3779b9;
  localparam key_t MULT_A = 32'h7feb352d;
  localparam key_t MULT_B = 32'h846ca68b;
  localparam int unsigned SHIFT_A = 16;
  localparam int unsigned SHIFT_B = 15;

  // Modulo reduction: 4 quotient bits per cycle
  localparam int unsigned DIG_BITS  = 4;
  localparam int unsigned MOD_STEPS = KEY_W / DIG_BITS;
  localparam int unsigned DIG_CNT_W = $clog2(MOD_STEPS);

endpackage

`default_nettype wire

// File: rtl/iterated_hash_histogram.sv
`default_nettype none

// Channel    Dir  Handshake               Payload
// ---------  ---  ----------------------  --------------------------------------
// request    in   in_valid_i / in_stall_o command_i, key_i, rounds_i, read_bucket_i
// result     out  out_valid_o/out_stall_i bucket_o, count_o, total_items_o
// config     in   cfg_valid_i/cfg_ready_o cfg_data_i (bucket total)
//
// Add: any mixer rounds, modulo reduction, memory read and update; read: memory read and update.
// Each mixer round uses the shared 32x32 multiplier twice;
// the modulo reduction works at 4 bits per cycle, then a memory read
// and a read-modify-write step.
// After reset a clearing pass zeroes the counter memory,
// with in_stall_o high; configuration writes are taken throughout.
// A request is accepted while a result waits; its completion waits on
// out_stall_i before updating the memory.

module iterated_hash_histogram #(
  parameter int unsigned MAX_BUCKETS = 4096,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // request channel
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire                      command_i,
  input  wire ihh_pkg::key_t       key_i,
  input  wire ihh_pkg::rounds_t    rounds_i,
  input  wire ihh_pkg::bkt_t       read_bucket_i,
  // result channel
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output ihh_pkg::bkt_t            bucket_o,
  output ihh_pkg::out_word_t       count_o,
  output ihh_pkg::out_word_t       total_items_o,
  // config channel
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire ihh_pkg::cfg_word_t  cfg_data_i
);

  import ihh_pkg::*;

  localparam int unsigned IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BUCKETS - 1);

  // Sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [IDX_W-1:0]       clr_q;
  logic                   out_valid_q;
  out_word_t              items_q;
  cfg_word_t              bc_q;

  key_t                   v_q;
  rounds_t                round_q, rounds_q;
  logic [CFG_W-1:0]       rem_q;
  logic [DIG_CNT_W-1:0]   dig_q;
  logic                   cmd_q;
  logic                   oob_q;
  logic [IDX_W-1:0]       addr_q;
  bkt_t                   bkt_q;
  bkt_t                   out_bkt_q;
  out_word_t              out_cnt_q;
  out_word_t              out_tot_q;

  logic [COUNT_WIDTH-1:0] mem_q [MAX_BUCKETS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic                   in_acc;
  logic                   out_free;
  logic                   upd_go;
  cfg_word_t              div_n;
  key_t                   mix_t, mul_a, mul_b, prod, fin;
  logic [CFG_W-1:0]       rem_nxt;
  logic [COUNT_WIDTH-1:0] new_cnt;
  out_word_t              items_nxt;

  // Saturate a counter value to the 32-bit result field
  function automatic out_word_t sat_out(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] c64;
    c64 = 64'(c);
    if (c64 > 64'h0000_0000_FFFF_FFFF) begin
      sat_out = '1;
    end else begin
      sat_out = c64[31:0];
    end
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign upd_go      = (state_q == S_UPD) && out_free;

  // Effective bucket count, clamped to 1..MAX_BUCKETS
  always_comb begin
    if (bc_q == '0) begin
      div_n = CFG_W'(1);
    end else if (32'(bc_q) > 32'(MAX_BUCKETS)) begin
      div_n = CFG_W'(MAX_BUCKETS);
    end else begin
      div_n = bc_q;
    end
  end

  // Shared multiplier: first or second half of a mixer round
  assign mix_t = v_q + GOLDEN + KEY_W'(round_q);
  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = mix_t ^ (mix_t >> SHIFT_A);
      mul_b = MULT_A;
    end else begin
      mul_a = v_q ^ (v_q >> SHIFT_B);
      mul_b = MULT_B;
    end
  end
  assign prod = mul_a * mul_b;
  assign fin  = prod ^ (prod >> SHIFT_A);

  // One modulo digit: restoring steps over the top bits of v_q
  always_comb begin
    logic [CFG_W:0] r;
    rem_nxt = rem_q;
    for (int k = 0; k < DIG_BITS; k++) begin
      r = {rem_nxt, v_q[KEY_W-1-k]};
      if (r >= {1'b0, div_n}) begin
        r = r - {1'b0, div_n};
      end
      rem_nxt = r[CFG_W-1:0];
    end
  end

  // Counter update with saturation
  assign new_cnt   = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
  assign items_nxt = (items_q == '1) ? items_q : items_q + 1'b1;

  // Memory port control
  assign mem_addr  = (state_q == S_CLR) ? clr_q : addr_q;
  assign mem_we    = (state_q == S_CLR) || (upd_go && (cmd_q == CMD_ADD));
  assign mem_wdata = (state_q == S_CLR) ? '0 : new_cnt;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (command_i == CMD_READ)  state_d = S_RD;
          else if (rounds_i == '0)    state_d = S_MOD;
          else                        state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        state_d = (round_q + 1'b1 == rounds_q) ? S_MOD : S_MUL1;
      end
      S_MOD: begin
        if (dig_q == DIG_CNT_W'(MOD_STEPS - 1)) state_d = S_RD;
      end
      S_RD:  state_d = S_UPD;
      S_UPD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      items_q     <= '0;
      bc_q        <= CFG_W'(4096);
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) bc_q <= cfg_data_i;
      if (upd_go) begin
        out_valid_q <= 1'b1;
        if (cmd_q == CMD_ADD) items_q <= items_nxt;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= command_i;
          v_q      <= key_i;
          rounds_q <= rounds_i;
          round_q  <= '0;
          rem_q    <= '0;
          dig_q    <= '0;
          addr_q   <= IDX_W'(read_bucket_i);
          bkt_q    <= read_bucket_i;
          oob_q    <= (32'(read_bucket_i) >= 32'(MAX_BUCKETS));
        end
      end
      S_MUL1: v_q <= prod;
      S_MUL2: begin
        v_q     <= fin;
        round_q <= round_q + 1'b1;
      end
      S_MOD: begin
        v_q   <= v_q << DIG_BITS;
        rem_q <= rem_nxt;
        dig_q <= dig_q + 1'b1;
        if (dig_q == DIG_CNT_W'(MOD_STEPS - 1)) begin
          addr_q <= IDX_W'(rem_nxt);
          bkt_q  <= BKT_W'(rem_nxt);
          oob_q  <= 1'b0;
        end
      end
      default: ;
    endcase

    // result register
    if (upd_go) begin
      out_bkt_q <= bkt_q;
      if (cmd_q == CMD_ADD) begin
        out_cnt_q <= sat_out(new_cnt);
        out_tot_q <= items_nxt;
      end else begin
        out_cnt_q <= oob_q ? '0 : sat_out(rd_data_q);
        out_tot_q <= items_q;
      end
    end
  end

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rd_data_q <= mem_q[mem_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign bucket_o      = out_bkt_q;
  assign count_o       = out_cnt_q;
  assign total_items_o = out_tot_q;

`ifndef SYNTHESIS
  // remainder stays below the divisor during reduction
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (rem_q < div_n))
    else $error("modulo remainder out of range");

  // add always addresses a bucket inside the store
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && cmd_q == CMD_ADD) |-> (32'(addr_q) < 32'(MAX_BUCKETS)))
    else $error("bucket index beyond store");

  // a new result comes only from the update cycle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_UPD))
    else $error("result without update");

  // round counter never passes the requested count
  a_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2) |-> (round_q < rounds_q))
    else $error("round counter overrun");

  // item total never goes down
  a_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (items_q >= $past(items_q)))
    else $error("item total decreased");
`endif

endmodule

`default_nettype wire

// File: verif/iterated_hash_histogram_tb.sv
`timescale 1ns / 100ps

module iterated_hash_histogram_tb;
  import ihh_pkg::*;

  localparam int unsigned MAX_BUCKETS = 4096;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS = 95;
  localparam int unsigned HEAVY_CAP   = 3;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic    cmd;
    key_t    key;
    rounds_t rounds;
    bkt_t    rd;
  } request_t;

  typedef struct packed {
    bkt_t      bucket;
    out_word_t count;
    out_word_t total;
  } hist_result_t;

  // DUT-facing signals; the inputs are all known from time zero
  logic      clk_i         = 1'b0;
  logic      rst_ni        = 1'b0;
  logic      in_valid_i    = 1'b0;
  logic      in_stall_o;
  logic      command_i     = CMD_ADD;
  key_t      key_i         = '0;
  rounds_t   rounds_i      = '0;
  bkt_t      read_bucket_i = '0;
  logic      out_valid_o;
  logic      out_stall_i   = 1'b0;
  bkt_t      bucket_o;
  out_word_t count_o;
  out_word_t total_items_o;
  logic      cfg_valid_i   = 1'b0;
  logic      cfg_ready_o;
  cfg_word_t cfg_data_i    = '0;

  // Histogram shadow state
  logic [COUNT_WIDTH-1:0] hist_count [MAX_BUCKETS];
  out_word_t items_total;
  key_t      last_hash;
  rounds_t   last_rounds;
  cfg_word_t bucket_cfg;

  request_t     pending_reqs [$];
  hist_result_t due_results [$];
  bkt_t         hit_buckets [$];
  request_t     cur_req;

  int unsigned queued_reqs   = 0;
  int unsigned accepted_reqs = 0;
  int unsigned mismatches    = 0;
  int unsigned adds_done     = 0;
  int unsigned reads_done    = 0;
  int unsigned settings_done = 0;
  int unsigned longest_chain = 0;
  int unsigned heavy_left    = HEAVY_CAP;
  int unsigned send_gap      = 0;
  int unsigned hold_left     = 0;
  bit          send_burst    = 1'b0;
  bit          recv_burst    = 1'b0;
  longint unsigned cycle_count = 0;

  iterated_hash_histogram #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .rounds_i     (rounds_i),
    .read_bucket_i(read_bucket_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bucket_o     (bucket_o),
    .count_o      (count_o),
    .total_items_o(total_items_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register value 0 behaves as one bucket, anything past the store as the full store
  function automatic logic [31:0] effective_buckets(cfg_word_t c);
    if (c == '0) return 32'd1;
    if (c > MAX_BUCKETS) return MAX_BUCKETS;
    return {19'd0, c};
  endfunction

  // Add: hash the key and bump its counter; read: look it up; return the expected result
  function automatic hist_result_t hash_and_count(request_t r);
    key_t         v;
    logic [31:0]  i;
    hist_result_t res;
    if (r.cmd == CMD_ADD) begin
      v = r.key;
      for (i = 0; i < r.rounds; i++) begin
        v = v + GOLDEN + i;
        v ^= v >> SHIFT_A;
        v = v * MULT_A;
        v ^= v >> SHIFT_B;
        v = v * MULT_B;
        v ^= v >> SHIFT_A;
      end
      last_hash   = v;
      last_rounds = r.rounds;
      res.bucket  = bkt_t'(v % effective_buckets(bucket_cfg));
      if (hist_count[res.bucket] != '1) hist_count[res.bucket]++;
      if (items_total != '1) items_total++;
      res.count = hist_count[res.bucket];
      hit_buckets.push_back(res.bucket);
      if (hit_buckets.size() > 64) void'(hit_buckets.pop_front());
      adds_done++;
      if (r.rounds > longest_chain) longest_chain = r.rounds;
    end else begin
      res.bucket = r.rd;
      res.count  = (r.rd < MAX_BUCKETS) ? hist_count[r.rd] : '0;
      reads_done++;
    end
    res.total = items_total;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
    end
  endtask

  // Request driver: gap drawn after every accepted request
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    logic busy;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      command_i     <= CMD_ADD;
      key_i         <= '0;
      rounds_i      <= '0;
      read_bucket_i <= '0;
      send_gap = 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(hash_and_count(cur_req));
        accepted_reqs++;
        busy = 1'b0;
        send_gap = send_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      end
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= cur_req.cmd;
          key_i         <= cur_req.key;
          rounds_i      <= cur_req.rounds;
          read_bucket_i <= cur_req.rd;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall drawn per result, counted down while a result is offered
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    hist_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual bucket %0d count %0d",
                   $time, bucket_o, count_o);
        end else begin
          want = due_results.pop_front();
          check_field("bucket", {20'd0, want.bucket}, {20'd0, bucket_o});
          check_field("count", want.count, count_o);
          check_field("total_items", want.total, total_items_o);
        end
        hold_left = recv_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      end else if (out_valid_o && hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_request(logic cmd, key_t key, rounds_t rounds, bkt_t rd);
    request_t r;
    r.cmd    = cmd;
    r.key    = key;
    r.rounds = rounds;
    r.rd     = rd;
    pending_reqs.push_back(r);
    queued_reqs++;
  endtask

  // Hold the sender until every request has come back, then let the engine settle
  task automatic wait_drained();
    while (accepted_reqs != queued_reqs || due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bucket_cfg(cfg_word_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bucket_cfg = value;
    settings_done++;
  endtask

  // Mostly light adds, some over a small key pool; reads often aim at recently hit buckets
  task automatic push_random(key_t key_pool [8]);
    request_t    r;
    int unsigned pick;
    logic [31:0] n_eff;
    n_eff    = effective_buckets(bucket_cfg);
    r.cmd    = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ADD;
    r.key    = $urandom;
    r.rounds = $urandom;
    r.rd     = $urandom;
    if (r.cmd == CMD_ADD) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) r.key = key_pool[$urandom_range(0, 7)];
      else if (pick == 3) r.key = 32'h1 << $urandom_range(0, 31);
      else if (pick == 4) r.key = ~(32'h1 << $urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r.rounds = $urandom_range(0, 6);
      end else if (pick < 97 || heavy_left == 0) begin
        r.rounds = $urandom_range(7, 255);
      end else begin
        heavy_left--;
        r.rounds = $urandom_range(256, 65535);
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && hit_buckets.size() != 0)
        r.rd = hit_buckets[$urandom_range(0, hit_buckets.size() - 1)];
      else if (pick < 6)
        r.rd = $urandom_range(0, n_eff - 1);
    end
    push_request(r.cmd, r.key, r.rounds, r.rd);
  endtask

  initial begin : stimulus
    key_t        key_pool [8];
    cfg_word_t   settings [NUM_PHASES];
    int unsigned ph;
    int unsigned k;

    foreach (hist_count[b]) hist_count[b] = '0;
    items_total = '0;
    last_hash   = '0;
    last_rounds = '0;
    bucket_cfg  = 13'd4096;
    key_pool[0] = '0;
    for (k = 1; k < 8; k++) key_pool[k] = $urandom;
    settings = '{13'd0, 13'd1, 13'd3, 13'd8191, 13'd4097, 13'd17, 13'd4096, 13'd0, 13'd0};
    settings[7] = $urandom_range(2, 4096);
    settings[8] = $urandom_range(1, 64);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: key and field extremes at the reset bucket count
    push_request(CMD_ADD, 32'h0000_0000, 16'd0, 12'd0);
    push_request(CMD_ADD, 32'hFFFF_FFFF, 16'd0, 12'hFFF);
    push_request(CMD_ADD, 32'h0000_0000, 16'd0, 12'h5A5);
    push_request(CMD_READ, 32'hFFFF_FFFF, 16'hFFFF, 12'd0);
    push_request(CMD_READ, 32'h0000_0000, 16'd0, 12'hFFF);
    push_request(CMD_READ, $urandom, $urandom, 12'd1);
    push_request(CMD_ADD, 32'h0000_0000, 16'd1, 12'd0);
    push_request(CMD_ADD, 32'hFFFF_FFFF, 16'd1, 12'd0);
    push_request(CMD_ADD, 32'h1234_5678, 16'd2, 12'hFFF);
    push_request(CMD_ADD, 32'hA5A5_A5A5, 16'd3, 12'd0);
    push_request(CMD_ADD, 32'h5A5A_5A5A, 16'h00FF, 12'd0);
    push_request(CMD_ADD, 32'hDEAD_BEEF, 16'hFFFF, 12'd0);
    push_request(CMD_READ, 32'h0000_0000, 16'd0, 12'h800);
    push_request(CMD_READ, 32'h0000_0000, 16'd0, 12'h7FF);
    wait_drained();

    // One phase per bucket-count setting, with a full drain halfway through
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_bucket_cfg(settings[ph]);
      if (ph == 0) begin
        // Zero buckets act as one; the top bucket keeps its count from before
        push_request(CMD_ADD, $urandom, 16'd5, 12'hFFF);
        push_request(CMD_ADD, 32'hFFFF_FFFF, 16'd0, 12'd0);
        push_request(CMD_READ, 32'h0000_0000, 16'd0, 12'd0);
        push_request(CMD_READ, 32'h0000_0000, 16'd0, 12'hFFF);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        push_random(key_pool);
        if (k == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d adds and %0d reads across %0d bucket-count writes (0, 1, 8191, 4097 among them)",
             adds_done, reads_done, settings_done);
    $display("Longest hash chain %0d rounds, %0d mismatches", longest_chain, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ihh_pkg.sv
rtl/iterated_hash_histogram.sv
verif/iterated_hash_histogram_tb.sv
